/* design/spd_pkg.sv */
// Shared constants, codes and types of the slotted page directory.
// Depends on nothing; used by slotted_page_directory.
package spd_pkg;

  localparam int PAGE_BYTES       = 4096;
  localparam int MAX_SLOTS        = 256;
  localparam int HEADER_BYTES     = 24;
  localparam int SLOT_ENTRY_BYTES = 8;

  localparam int SLOT_W = $clog2(MAX_SLOTS);   // slot index
  localparam int CNT_W  = SLOT_W + 1;          // slot count, holds MAX_SLOTS itself
  localparam int OFF_W  = 13;                  // record offset
  localparam int SIZE_W = 14;                  // signed record size
  localparam int LEN_W  = 13;                  // length field
  localparam int STAT_W = 3;
  localparam int OP_W   = 3;
  localparam int AR_W   = 16;                  // signed width for space arithmetic

  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
  localparam logic [OP_W-1:0] OP_GET    = 3'd2;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
  localparam logic [OP_W-1:0] OP_UPDATE = 3'd4;
  localparam logic [OP_W-1:0] OP_FIRST  = 3'd5;
  localparam logic [OP_W-1:0] OP_NEXT   = 3'd6;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_NO_SPACE = 3'd1;
  localparam logic [STAT_W-1:0] ST_RANGE    = 3'd2;
  localparam logic [STAT_W-1:0] ST_DELETED  = 3'd3;
  localparam logic [STAT_W-1:0] ST_NONE     = 3'd4;

  // One directory entry as held in the slot RAM.
  typedef struct packed {
    logic signed [SIZE_W-1:0] size;
    logic        [OFF_W-1:0]  off;
  } entry_t;

endpackage

/* design/slotted_page_directory.sv */
// Top level of the slotted page directory: sequencer, page header registers
// and result register. Depends on spd_pkg and spd_ram.
//
//  channel | ports         | moves per transfer
//  --------+---------------+-------------------------------------------------
//  in      | in_t*         | one operation: op in tuser, slot and length
//  out     | out_t*        | one result: status in tuser, slot/offset/size
//
// Sequence: clear, insert, unused codes and out-of-range slots pass through
// S_DISPATCH and S_RESP; get, delete and update add S_CHECK, and an update that
// resizes slot s also walks the later slots in S_SHIFT; a scan visits entries
// in S_SCAN. The next transfer is taken once the sequencer is back in S_IDLE.
// Reset: free pointer to page size, slot count to zero; RAM is not cleared.
// Stalls: one operation in flight; a result waits in a staging register while
// the output register is full, which holds off the input.
module slotted_page_directory (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] slot, [20:8] length, [23:21] zero
  input  logic [2:0]  in_tuser,   // [2:0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [7:0] slot_out, [20:8] offset_out,
                                  // [33:21] size_out, [39:34] zero
  output logic [2:0]  out_tuser   // [2:0] status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_CHECK,
    S_SHIFT,
    S_SCAN,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;

  // Latched operation.
  logic [spd_pkg::OP_W-1:0]   op_r, op_nxt;
  logic [spd_pkg::SLOT_W-1:0] slot_r, slot_nxt;
  logic [spd_pkg::LEN_W-1:0]  len_r, len_nxt;

  // Page header.
  logic [spd_pkg::OFF_W-1:0]  free_ptr_r, free_ptr_nxt;
  logic [spd_pkg::CNT_W-1:0]  slot_cnt_r, slot_cnt_nxt;

  // Walk control: ptr_r names the entry whose data is on the RAM output.
  logic [spd_pkg::SLOT_W-1:0] ptr_r, ptr_nxt;
  logic [spd_pkg::OFF_W-1:0]  shift_r, shift_nxt;

  // Staged result and output register.
  logic [spd_pkg::STAT_W-1:0] res_status_r, res_status_nxt;
  logic [spd_pkg::SLOT_W-1:0] res_slot_r, res_slot_nxt;
  logic [spd_pkg::OFF_W-1:0]  res_off_r, res_off_nxt;
  logic [spd_pkg::LEN_W-1:0]  res_size_r, res_size_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [spd_pkg::STAT_W-1:0] out_status_r, out_status_nxt;
  logic [spd_pkg::SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic [spd_pkg::OFF_W-1:0]  out_off_r, out_off_nxt;
  logic [spd_pkg::LEN_W-1:0]  out_size_r, out_size_nxt;

  // Directory RAM ports.
  logic                       ram_we;
  logic [spd_pkg::SLOT_W-1:0] ram_waddr;
  spd_pkg::entry_t            ram_wdata;
  logic [spd_pkg::SLOT_W-1:0] ram_raddr;
  spd_pkg::entry_t            ram_rdata;

  spd_ram #(
    .WIDTH($bits(spd_pkg::entry_t)),
    .DEPTH(spd_pkg::MAX_SLOTS)
  ) u_dir_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Space arithmetic, all in one signed width.
  logic signed [spd_pkg::AR_W-1:0] free_space;
  logic signed [spd_pkg::AR_W-1:0] len_s;
  logic signed [spd_pkg::AR_W-1:0] size_s;
  logic signed [spd_pkg::AR_W-1:0] upd_shift;
  logic [spd_pkg::CNT_W-1:0]       scan_start;
  logic [spd_pkg::CNT_W-1:0]       ptr_inc;
  logic [spd_pkg::CNT_W-1:0]       slot_inc;
  logic                            live;

  assign free_space = $signed({{(spd_pkg::AR_W-spd_pkg::OFF_W){1'b0}}, free_ptr_r})
                    - $signed(spd_pkg::AR_W'(spd_pkg::HEADER_BYTES))
                    - $signed({{(spd_pkg::AR_W-spd_pkg::CNT_W-3){1'b0}}, slot_cnt_r, 3'b000});
  assign len_s      = $signed({{(spd_pkg::AR_W-spd_pkg::LEN_W){1'b0}}, len_r});
  assign size_s     = {{(spd_pkg::AR_W-spd_pkg::SIZE_W){ram_rdata.size[spd_pkg::SIZE_W-1]}},
                       ram_rdata.size};
  assign upd_shift  = size_s - len_s;
  assign slot_inc   = {1'b0, slot_r} + spd_pkg::CNT_W'(1);
  assign ptr_inc    = {1'b0, ptr_r} + spd_pkg::CNT_W'(1);
  assign scan_start = (op_r == spd_pkg::OP_FIRST) ? '0 : slot_inc;
  assign live       = !ram_rdata.size[spd_pkg::SIZE_W-1] && (ram_rdata.size != '0);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {6'b000000, out_size_r, out_off_r, out_slot_r};

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    slot_nxt       = slot_r;
    len_nxt        = len_r;
    free_ptr_nxt   = free_ptr_r;
    slot_cnt_nxt   = slot_cnt_r;
    shift_nxt      = shift_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_off_nxt    = res_off_r;
    res_size_nxt   = res_size_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_off_nxt    = out_off_r;
    out_size_nxt   = out_size_r;
    ram_we         = 1'b0;
    ram_waddr      = ptr_r;
    ram_wdata      = ram_rdata;
    ram_raddr      = ptr_r;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = in_tuser;
          slot_nxt  = in_tdata[7:0];
          len_nxt   = in_tdata[20:8];
          state_nxt = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        // Failures and trivial ops answer with zero fields.
        res_status_nxt = spd_pkg::ST_OK;
        res_slot_nxt   = '0;
        res_off_nxt    = '0;
        res_size_nxt   = '0;
        state_nxt      = S_RESP;
        case (op_r)
          spd_pkg::OP_CLEAR: begin
            free_ptr_nxt = spd_pkg::OFF_W'(spd_pkg::PAGE_BYTES);
            slot_cnt_nxt = '0;
          end
          spd_pkg::OP_INSERT: begin
            if (slot_cnt_r >= spd_pkg::CNT_W'(spd_pkg::MAX_SLOTS) ||
                free_space < len_s + spd_pkg::AR_W'(spd_pkg::SLOT_ENTRY_BYTES)) begin
              res_status_nxt = spd_pkg::ST_NO_SPACE;
            end else begin
              ram_we         = 1'b1;
              ram_waddr      = slot_cnt_r[spd_pkg::SLOT_W-1:0];
              ram_wdata.size = $signed({1'b0, len_r});
              ram_wdata.off  = free_ptr_r - len_r;
              free_ptr_nxt   = free_ptr_r - len_r;
              slot_cnt_nxt   = slot_cnt_r + spd_pkg::CNT_W'(1);
              res_slot_nxt   = slot_cnt_r[spd_pkg::SLOT_W-1:0];
              res_off_nxt    = free_ptr_r - len_r;
              res_size_nxt   = len_r;
            end
          end
          spd_pkg::OP_GET, spd_pkg::OP_DELETE, spd_pkg::OP_UPDATE: begin
            if ({1'b0, slot_r} >= slot_cnt_r) begin
              res_status_nxt = spd_pkg::ST_RANGE;
            end else begin
              ram_raddr = slot_r;
              state_nxt = S_CHECK;
            end
          end
          spd_pkg::OP_FIRST, spd_pkg::OP_NEXT: begin
            if (scan_start >= slot_cnt_r) begin
              res_status_nxt = spd_pkg::ST_NONE;
            end else begin
              ram_raddr = scan_start[spd_pkg::SLOT_W-1:0];
              state_nxt = S_SCAN;
            end
          end
          default: begin
          end
        endcase
      end

      S_CHECK: begin
        // Entry of slot_r is on the RAM output.
        state_nxt = S_RESP;
        if (ram_rdata.size[spd_pkg::SIZE_W-1]) begin
          res_status_nxt = spd_pkg::ST_DELETED;
        end else begin
          case (op_r)
            spd_pkg::OP_GET: begin
              res_slot_nxt = slot_r;
              res_off_nxt  = ram_rdata.off;
              res_size_nxt = ram_rdata.size[spd_pkg::LEN_W-1:0];
            end
            spd_pkg::OP_DELETE: begin
              ram_we         = 1'b1;
              ram_waddr      = slot_r;
              ram_wdata.size = -ram_rdata.size;
              res_slot_nxt   = slot_r;
              res_off_nxt    = ram_rdata.off;
              res_size_nxt   = ram_rdata.size[spd_pkg::LEN_W-1:0];
            end
            default: begin
              // Update.
              if (len_s == size_s) begin
                res_slot_nxt = slot_r;
                res_off_nxt  = ram_rdata.off;
                res_size_nxt = len_r;
              end else if (free_space < len_s - size_s) begin
                res_status_nxt = spd_pkg::ST_NO_SPACE;
              end else begin
                ram_we         = 1'b1;
                ram_waddr      = slot_r;
                ram_wdata.size = $signed({1'b0, len_r});
                ram_wdata.off  = ram_rdata.off + upd_shift[spd_pkg::OFF_W-1:0];
                free_ptr_nxt   = free_ptr_r + upd_shift[spd_pkg::OFF_W-1:0];
                shift_nxt      = upd_shift[spd_pkg::OFF_W-1:0];
                res_slot_nxt   = slot_r;
                res_off_nxt    = ram_rdata.off + upd_shift[spd_pkg::OFF_W-1:0];
                res_size_nxt   = len_r;
                // Move the offsets of every later slot as well.
                if (slot_inc < slot_cnt_r) begin
                  ram_raddr = slot_inc[spd_pkg::SLOT_W-1:0];
                  state_nxt = S_SHIFT;
                end
              end
            end
          endcase
        end
      end

      S_SHIFT: begin
        // Write back entry ptr_r while the next one is read.
        ram_we        = 1'b1;
        ram_waddr     = ptr_r;
        ram_wdata.off = ram_rdata.off + shift_r;
        if (ptr_inc < slot_cnt_r) begin
          ram_raddr = ptr_inc[spd_pkg::SLOT_W-1:0];
        end else begin
          state_nxt = S_RESP;
        end
      end

      S_SCAN: begin
        if (live) begin
          res_status_nxt = spd_pkg::ST_OK;
          res_slot_nxt   = ptr_r;
          res_off_nxt    = ram_rdata.off;
          res_size_nxt   = ram_rdata.size[spd_pkg::LEN_W-1:0];
          state_nxt      = S_RESP;
        end else if (ptr_inc < slot_cnt_r) begin
          ram_raddr = ptr_inc[spd_pkg::SLOT_W-1:0];
        end else begin
          res_status_nxt = spd_pkg::ST_NONE;
          state_nxt      = S_RESP;
        end
      end

      S_RESP: begin
        // Hold until the output register is free, then load it.
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = res_slot_r;
          out_off_nxt    = res_off_r;
          out_size_nxt   = res_size_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    ptr_nxt = ram_raddr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_ptr_r  <= spd_pkg::OFF_W'(spd_pkg::PAGE_BYTES);
      slot_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_ptr_r  <= free_ptr_nxt;
      slot_cnt_r  <= slot_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    slot_r       <= slot_nxt;
    len_r        <= len_nxt;
    ptr_r        <= ptr_nxt;
    shift_r      <= shift_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_off_r    <= res_off_nxt;
    res_size_r   <= res_size_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_off_r    <= out_off_nxt;
    out_size_r   <= out_size_nxt;
  end

endmodule

/* design/spd_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module spd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
